// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the blitter RTL.
// Define NO_ASSERTIONS to compile the checks out; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

// Same check with a message of the caller's choosing.
`define ASSERT_CLK_MSG(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_CLK_MSG(label, clk, rst_n, prop, msg)

`endif

`endif

// ----- hdl/cab_pkg.sv -----
// Shared types and constants of the clipped alpha blitter.
// No dependencies; used by the interfaces, the blend unit and the top level.
package cab_pkg;

  localparam int unsigned CAB_CANVAS_WIDTH  = 1024;
  localparam int unsigned CAB_CANVAS_HEIGHT = 1024;

  localparam int unsigned CAB_CH_W       = 8;
  localparam int unsigned CAB_IDX_W      = 20;
  localparam int unsigned CAB_COORD_W    = 13;
  localparam int unsigned CAB_SPAN_W     = 14;
  localparam int unsigned CAB_COL_W      = 12;
  localparam int unsigned CAB_ROW_W      = 13;
  localparam int unsigned CAB_CFG_IDX_W  = 3;
  localparam int unsigned CAB_CFG_DATA_W = 14;

  localparam logic [CAB_CH_W-1:0] CAB_OPAQUE = 8'd255;

  typedef enum logic [CAB_CFG_IDX_W-1:0] {
    CFG_DEST_X       = 3'd0,
    CFG_DEST_Y       = 3'd1,
    CFG_SOURCE_WIDTH = 3'd2,
    CFG_CLIP_LEFT    = 3'd3,
    CFG_CLIP_TOP     = 3'd4,
    CFG_CLIP_SPAN_X  = 3'd5,
    CFG_CLIP_SPAN_Y  = 3'd6
  } cab_cfg_idx_t;

  typedef logic [CAB_CH_W-1:0] cab_chan_t;

  typedef struct packed {
    cab_chan_t src_red;
    cab_chan_t src_green;
    cab_chan_t src_blue;
    cab_chan_t src_alpha;
    cab_chan_t dst_red;
    cab_chan_t dst_green;
    cab_chan_t dst_blue;
  } cab_pix_t;

endpackage

// ----- hdl/cab_in_if.sv -----
// Input channel of the blitter: source RGBA plus canvas RGB per transaction.
// Depends on cab_pkg.
interface cab_in_if
  import cab_pkg::*;
();
  logic      valid;
  logic      ready;
  cab_chan_t src_red;
  cab_chan_t src_green;
  cab_chan_t src_blue;
  cab_chan_t src_alpha;
  cab_chan_t dst_red;
  cab_chan_t dst_green;
  cab_chan_t dst_blue;
  logic      last_pixel;

  modport source (
    output valid, src_red, src_green, src_blue, src_alpha,
           dst_red, dst_green, dst_blue, last_pixel,
    input  ready
  );
  modport sink (
    input  valid, src_red, src_green, src_blue, src_alpha,
           dst_red, dst_green, dst_blue, last_pixel,
    output ready
  );
endinterface

// ----- hdl/cab_out_if.sv -----
// Result channel of the blitter: canvas write per transaction.
// Depends on cab_pkg.
interface cab_out_if
  import cab_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic                 write_enable;
  logic [CAB_IDX_W-1:0] pixel_index;
  cab_chan_t            out_red;
  cab_chan_t            out_green;
  cab_chan_t            out_blue;

  modport source (
    output valid, write_enable, pixel_index, out_red, out_green, out_blue,
    input  ready
  );
  modport sink (
    input  valid, write_enable, pixel_index, out_red, out_green, out_blue,
    output ready
  );
endinterface

// ----- hdl/cab_blend.sv -----
// One color channel of the alpha blend: copy when opaque, else
// (src*a + dst*(255-a)) / 255 truncated. Depends on cab_pkg.
module cab_blend
  import cab_pkg::*;
(
  input  cab_chan_t src,
  input  cab_chan_t dst,
  input  cab_chan_t alpha,
  output cab_chan_t result
);

  logic [15:0] src_term;
  logic [15:0] dst_term;
  logic [15:0] mix;
  logic [16:0] quot_pre;

  assign src_term = 16'(src) * 16'(alpha);
  assign dst_term = 16'(dst) * 16'(CAB_OPAQUE - alpha);
  // Sum tops out at 255*255, so it fits 16 bits.
  assign mix      = src_term + dst_term;
  // Exact divide by 255 for any sum up to 255*255.
  assign quot_pre = 17'(mix) + 17'd1 + 17'(mix[15:8]);

  assign result = (alpha == CAB_OPAQUE) ? src : quot_pre[15:8];

endmodule

// ----- hdl/clipped_alpha_blit_unit.sv -----
// Top level of the clipped alpha blitter: counters, clip test, blend, index.
// Depends on cab_pkg, cab_in_if, cab_out_if, cab_blend and assert_macros.svh.
//
//   port      | direction | content
//   ----------+-----------+----------------------------------------------
//   in_px     | sink      | source RGBA, canvas RGB, last_pixel
//   out_px    | source    | write_enable, pixel_index, out RGB
//   cfg_*     | input     | write enable, register index, write data
//
// Two register stages: the input stage holds the pixel and its canvas
// coordinates, the output stage holds the finished write. A transaction
// accepted into the input stage moves to the output stage once that stage
// can advance, and its result then shows on out_px; one transaction per
// cycle is sustained while out_px is ready. A stalled output holds and
// back-pressures the input stage only once both stages are full.
// Reset (rst_n low, sync) clears the valid bits and the counters and sets
// the configuration registers to their defaults.
`include "assert_macros.svh"

module clipped_alpha_blit_unit
  import cab_pkg::*;
#(
  parameter int unsigned CANVAS_WIDTH  = CAB_CANVAS_WIDTH,
  parameter int unsigned CANVAS_HEIGHT = CAB_CANVAS_HEIGHT
)(
  input  logic                      clk,
  input  logic                      rst_n,
  cab_in_if.sink                    in_px,
  cab_out_if.source                 out_px,
  input  logic                      cfg_we,
  input  logic [CAB_CFG_IDX_W-1:0]  cfg_index,
  input  logic [CAB_CFG_DATA_W-1:0] cfg_wdata
);

  localparam logic signed [15:0] CanvasW = 16'(CANVAS_WIDTH);
  localparam logic signed [15:0] CanvasH = 16'(CANVAS_HEIGHT);

  // Configuration registers
  logic signed [CAB_COORD_W-1:0] dest_x_r, dest_y_r, clip_left_r, clip_top_r;
  logic [CAB_COORD_W-1:0]        source_width_r;
  logic [CAB_SPAN_W-1:0]         clip_span_x_r, clip_span_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dest_x_r       <= '0;
      dest_y_r       <= '0;
      source_width_r <= 13'd1;
      clip_left_r    <= '0;
      clip_top_r     <= '0;
      clip_span_x_r  <= 14'd8192;
      clip_span_y_r  <= 14'd8192;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DEST_X:       dest_x_r       <= cfg_wdata[CAB_COORD_W-1:0];
        CFG_DEST_Y:       dest_y_r       <= cfg_wdata[CAB_COORD_W-1:0];
        CFG_SOURCE_WIDTH: source_width_r <= cfg_wdata[CAB_COORD_W-1:0];
        CFG_CLIP_LEFT:    clip_left_r    <= cfg_wdata[CAB_COORD_W-1:0];
        CFG_CLIP_TOP:     clip_top_r     <= cfg_wdata[CAB_COORD_W-1:0];
        CFG_CLIP_SPAN_X:  clip_span_x_r  <= cfg_wdata;
        CFG_CLIP_SPAN_Y:  clip_span_y_r  <= cfg_wdata;
        default: ;  // drop writes to unused indexes
      endcase
    end
  end

  // Handshake: advance the output stage when empty or drained, the input
  // stage when it is empty or can move forward.
  logic s1_valid_r, out_valid_r;
  logic out_adv, s1_adv, in_fire;

  assign out_adv     = !out_valid_r || out_px.ready;
  assign s1_adv      = !s1_valid_r || out_adv;
  assign in_px.ready = s1_adv;
  assign in_fire     = in_px.valid && in_px.ready;

  // Source position counters, advanced once per accepted transaction.
  logic [CAB_COL_W-1:0] col_r, col_nxt;
  logic [CAB_ROW_W-1:0] row_r, row_nxt;
  logic [CAB_COL_W:0]   col_inc;
  logic                 row_end;

  assign col_inc = {1'b0, col_r} + 13'd1;
  // End the row at source_width or when the column counter would wrap.
  assign row_end = (col_inc >= source_width_r) || col_inc[CAB_COL_W];

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_fire) begin
      if (in_px.last_pixel) begin
        col_nxt = '0;
        row_nxt = '0;
      end else if (row_end) begin
        col_nxt = '0;
        row_nxt = row_r + 13'd1;
      end else begin
        col_nxt = col_inc[CAB_COL_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
    end
  end

  // Input stage: pixel plus canvas coordinates.
  logic signed [14:0] px_nxt, py_nxt;
  logic signed [14:0] s1_px_r, s1_py_r;
  cab_pix_t           s1_pix_r;

  assign px_nxt = 15'(dest_x_r) + $signed({3'b000, col_r});
  assign py_nxt = 15'(dest_y_r) + $signed({2'b00, row_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_r <= in_px.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_px_r            <= px_nxt;
      s1_py_r            <= py_nxt;
      s1_pix_r.src_red   <= in_px.src_red;
      s1_pix_r.src_green <= in_px.src_green;
      s1_pix_r.src_blue  <= in_px.src_blue;
      s1_pix_r.src_alpha <= in_px.src_alpha;
      s1_pix_r.dst_red   <= in_px.dst_red;
      s1_pix_r.dst_green <= in_px.dst_green;
      s1_pix_r.dst_blue  <= in_px.dst_blue;
    end
  end

  // Clip against canvas and clip rectangle.
  logic signed [15:0] px16, py16, clip_l16, clip_t16, clip_r16, clip_b16;
  logic               inside_x, inside_y, keep;

  assign px16     = 16'(s1_px_r);
  assign py16     = 16'(s1_py_r);
  assign clip_l16 = 16'(clip_left_r);
  assign clip_t16 = 16'(clip_top_r);
  assign clip_r16 = clip_l16 + $signed({2'b00, clip_span_x_r});
  assign clip_b16 = clip_t16 + $signed({2'b00, clip_span_y_r});

  assign inside_x = (px16 >= 16'sd0) && (px16 < CanvasW) &&
                    (px16 >= clip_l16) && (px16 < clip_r16);
  assign inside_y = (py16 >= 16'sd0) && (py16 < CanvasH) &&
                    (py16 >= clip_t16) && (py16 < clip_b16);
  assign keep     = inside_x && inside_y && (s1_pix_r.src_alpha != '0);

  // Canvas index: both coordinates are below 4096 when kept.
  logic [24:0] idx_full;

  assign idx_full = 25'(s1_py_r[11:0]) * 25'(CANVAS_WIDTH) + 25'(s1_px_r[11:0]);

  // Blend, one unit per channel.
  cab_chan_t blend_red, blend_green, blend_blue;

  cab_blend u_blend_red (
    .src(s1_pix_r.src_red), .dst(s1_pix_r.dst_red),
    .alpha(s1_pix_r.src_alpha), .result(blend_red)
  );
  cab_blend u_blend_green (
    .src(s1_pix_r.src_green), .dst(s1_pix_r.dst_green),
    .alpha(s1_pix_r.src_alpha), .result(blend_green)
  );
  cab_blend u_blend_blue (
    .src(s1_pix_r.src_blue), .dst(s1_pix_r.dst_blue),
    .alpha(s1_pix_r.src_alpha), .result(blend_blue)
  );

  // Output stage: zero every field of a dropped pixel.
  logic                 we_r, we_nxt;
  logic [CAB_IDX_W-1:0] idx_r, idx_nxt;
  cab_chan_t            red_r, green_r, blue_r, red_nxt, green_nxt, blue_nxt;

  assign we_nxt    = keep;
  assign idx_nxt   = keep ? idx_full[CAB_IDX_W-1:0] : '0;
  assign red_nxt   = keep ? blend_red   : '0;
  assign green_nxt = keep ? blend_green : '0;
  assign blue_nxt  = keep ? blend_blue  : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv && s1_valid_r) begin
      we_r    <= we_nxt;
      idx_r   <= idx_nxt;
      red_r   <= red_nxt;
      green_r <= green_nxt;
      blue_r  <= blue_nxt;
    end
  end

  assign out_px.valid        = out_valid_r;
  assign out_px.write_enable = we_r;
  assign out_px.pixel_index  = idx_r;
  assign out_px.out_red      = red_r;
  assign out_px.out_green    = green_r;
  assign out_px.out_blue     = blue_r;

  // A final pixel returns both counters to the origin.
  `ASSERT_CLK(a_last_resets_pos, clk, rst_n,
    in_fire && in_px.last_pixel |=> col_r == '0 && row_r == '0)
  // A dropped pixel carries all-zero fields.
  `ASSERT_CLK_MSG(a_drop_zero, clk, rst_n,
    out_valid_r && !we_r |-> idx_r == '0 && red_r == '0 && green_r == '0 &&
      blue_r == '0, "dropped pixel has nonzero fields")
  // An opaque kept pixel has its red and blue channels copied unchanged.
  `ASSERT_CLK(a_opaque_copy, clk, rst_n,
    out_adv && s1_valid_r && keep && s1_pix_r.src_alpha == CAB_OPAQUE |=>
      red_r == $past(s1_pix_r.src_red) && blue_r == $past(s1_pix_r.src_blue))
  // A full input stage moving on always lands in the output stage.
  `ASSERT_CLK(a_stage_move, clk, rst_n,
    out_adv && s1_valid_r |=> out_valid_r)

endmodule

// ----- test/clipped_alpha_blit_unit_tb.sv -----
// Self-checking testbench of clipped_alpha_blit_unit: placement, clipping, blending.
// Depends on cab_pkg, cab_in_if, cab_out_if and the block itself; reads no files.
// Every accepted pixel is predicted here and compared with the canvas write it causes.
module clipped_alpha_blit_unit_tb
  import cab_pkg::*;
();

  // Geometry and limits in signed terms, so negative coordinates compare correctly
  localparam int CANVAS_W     = CAB_CANVAS_WIDTH;
  localparam int CANVAS_H     = CAB_CANVAS_HEIGHT;
  localparam int COL_LIMIT    = 1 << CAB_COL_W;
  localparam int ROW_MOD      = 1 << CAB_ROW_W;
  localparam int CH_MAX       = 255;
  localparam int COORD_MIN    = -4096;
  localparam int COORD_MAX    = 4095;
  localparam int SPAN_FULL    = 8192;
  localparam int SPAN_MAX     = 16383;
  localparam int WIDTH_MAX    = 8191;
  localparam int RANDOM_ITEMS = 470;
  localparam int SETTLE_CYCLES = 3;
  localparam int DRAIN_CYCLES = 10;
  localparam int MAX_REPORTS  = 10;
  localparam int HOLD_CYCLES  = 80;
  localparam int TIMEOUT      = 8_000_000;

  // Receiver stall patterns
  typedef enum int {
    RX_ALWAYS,
    RX_RANDOM,
    RX_PERIODIC
  } rx_mode_t;

  typedef struct packed {
    cab_pix_t pix;
    logic     last;
  } blit_item_t;

  typedef struct packed {
    logic                 we;
    logic [CAB_IDX_W-1:0] pixel_index;
    cab_chan_t            red;
    cab_chan_t            green;
    cab_chan_t            blue;
  } canvas_write_t;

  logic                      clk;
  logic                      rst_n;
  logic                      cfg_we;
  logic [CAB_CFG_IDX_W-1:0]  cfg_index;
  logic [CAB_CFG_DATA_W-1:0] cfg_wdata;

  cab_in_if  in_if ();
  cab_out_if out_if ();

  clipped_alpha_blit_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_px     (in_if),
    .out_px    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predicted register file and source counters
  int reg_dest_x;
  int reg_dest_y;
  int reg_src_width;
  int reg_clip_left;
  int reg_clip_top;
  int reg_span_x;
  int reg_span_y;
  int col_count;
  int row_count;

  canvas_write_t pending_writes[$];
  int            mismatch_count;

  // Sender and receiver pacing
  int burst_left;
  bit steady_send;
  int hold_off_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop in case the block hangs somewhere
  initial begin
    #(TIMEOUT);
    $display("clipped_alpha_blit_unit_tb NOT OK");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Mirror a register write into the predicted register file; 13-bit
  // coordinates are sign extended, spans keep all 14 bits.
  function automatic void apply_reg(cab_cfg_idx_t idx, logic [CAB_CFG_DATA_W-1:0] data);
    case (idx)
      CFG_DEST_X:       reg_dest_x    = int'($signed(data[CAB_COORD_W-1:0]));
      CFG_DEST_Y:       reg_dest_y    = int'($signed(data[CAB_COORD_W-1:0]));
      CFG_SOURCE_WIDTH: reg_src_width = int'(data[CAB_COORD_W-1:0]);
      CFG_CLIP_LEFT:    reg_clip_left = int'($signed(data[CAB_COORD_W-1:0]));
      CFG_CLIP_TOP:     reg_clip_top  = int'($signed(data[CAB_COORD_W-1:0]));
      CFG_CLIP_SPAN_X:  reg_span_x    = int'(data);
      CFG_CLIP_SPAN_Y:  reg_span_y    = int'(data);
      default: ;
    endcase
  endfunction

  function automatic cab_chan_t mix_channel(int s, int d, int a);
    return cab_chan_t'((s * a + d * (CH_MAX - a)) / CH_MAX);
  endfunction

  // Compute the canvas write for one pixel, then advance the source counters
  function automatic canvas_write_t predict_write(blit_item_t it);
    canvas_write_t w;
    int            px;
    int            py;
    int            a;
    bit            keep;
    px = reg_dest_x + col_count;
    py = reg_dest_y + row_count;
    a  = int'(it.pix.src_alpha);
    keep = px >= 0 && px < CANVAS_W && px >= reg_clip_left &&
           px < reg_clip_left + reg_span_x &&
           py >= 0 && py < CANVAS_H && py >= reg_clip_top &&
           py < reg_clip_top + reg_span_y && a != 0;
    w = '0;
    if (keep) begin
      w.we          = 1'b1;
      w.pixel_index = CAB_IDX_W'(py * CANVAS_W + px);
      if (a == CH_MAX) begin
        w.red   = it.pix.src_red;
        w.green = it.pix.src_green;
        w.blue  = it.pix.src_blue;
      end else begin
        w.red   = mix_channel(int'(it.pix.src_red), int'(it.pix.dst_red), a);
        w.green = mix_channel(int'(it.pix.src_green), int'(it.pix.dst_green), a);
        w.blue  = mix_channel(int'(it.pix.src_blue), int'(it.pix.dst_blue), a);
      end
    end
    if (it.last) begin
      col_count = 0;
      row_count = 0;
    end else if (col_count + 1 >= reg_src_width || col_count + 1 >= COL_LIMIT) begin
      col_count = 0;
      row_count = (row_count + 1) % ROW_MOD;
    end else begin
      col_count++;
    end
    return w;
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking: compare every accepted write with the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    canvas_write_t got;
    canvas_write_t want;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      got.we          = out_if.write_enable;
      got.pixel_index = out_if.pixel_index;
      got.red         = out_if.out_red;
      got.green       = out_if.out_green;
      got.blue        = out_if.out_blue;
      if (pending_writes.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("unexpected write: we=%0b idx=%0d rgb=%0d,%0d,%0d", got.we,
                   got.pixel_index, got.red, got.green, got.blue);
      end else begin
        want = pending_writes.pop_front();
        if (got.we !== want.we || got.pixel_index !== want.pixel_index ||
            got.red !== want.red || got.green !== want.green || got.blue !== want.blue) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("write mismatch: expected we=%0b idx=%0d rgb=%0d,%0d,%0d",
                     want.we, want.pixel_index, want.red, want.green, want.blue);
            $display("                got      we=%0b idx=%0d rgb=%0d,%0d,%0d",
                     got.we, got.pixel_index, got.red, got.green, got.blue);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: switch between stall patterns; honor a requested hold-off first
  // ---------------------------------------------------------------------------
  initial begin
    rx_mode_t rx_mode;
    int       mode_left;
    int       rx_tick;
    out_if.ready = 1'b0;
    mode_left    = 0;
    rx_tick      = 0;
    rx_mode      = RX_ALWAYS;
    forever begin
      @(negedge clk);
      rx_tick++;
      if (hold_off_cycles > 0) begin
        // Hold ready low so both stages fill and the input stalls
        out_if.ready <= 1'b0;
        hold_off_cycles--;
      end else begin
        if (mode_left == 0) begin
          rx_mode   = rx_mode_t'($urandom_range(RX_ALWAYS, RX_PERIODIC));
          mode_left = $urandom_range(10, 80);
        end
        mode_left--;
        case (rx_mode)
          RX_ALWAYS:   out_if.ready <= 1'b1;
          RX_RANDOM:   out_if.ready <= 1'($urandom_range(0, 1));
          RX_PERIODIC: out_if.ready <= (rx_tick % 4 == 0);
          default:     out_if.ready <= 1'b1;
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic blit_item_t make_pixel(int sr, int sg, int sb, int sa,
                                            int dr, int dg, int db, bit last);
    blit_item_t it;
    it.pix.src_red   = cab_chan_t'(sr);
    it.pix.src_green = cab_chan_t'(sg);
    it.pix.src_blue  = cab_chan_t'(sb);
    it.pix.src_alpha = cab_chan_t'(sa);
    it.pix.dst_red   = cab_chan_t'(dr);
    it.pix.dst_green = cab_chan_t'(dg);
    it.pix.dst_blue  = cab_chan_t'(db);
    it.last          = last;
    return it;
  endfunction

  // Random colors; alpha leans toward the transparent and opaque ends
  function automatic blit_item_t random_pixel(bit last);
    int a;
    case ($urandom_range(0, 4))
      0:       a = 0;
      1:       a = CH_MAX;
      default: a = $urandom_range(0, CH_MAX);
    endcase
    return make_pixel($urandom_range(0, CH_MAX), $urandom_range(0, CH_MAX),
                      $urandom_range(0, CH_MAX), a, $urandom_range(0, CH_MAX),
                      $urandom_range(0, CH_MAX), $urandom_range(0, CH_MAX), last);
  endfunction

  // Offer one pixel in bursts with random gaps; predict it once accepted
  task automatic send_pixel(blit_item_t it);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (steady_send || $urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        @(negedge clk);
        in_if.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    @(negedge clk);
    in_if.valid      <= 1'b1;
    in_if.src_red    <= it.pix.src_red;
    in_if.src_green  <= it.pix.src_green;
    in_if.src_blue   <= it.pix.src_blue;
    in_if.src_alpha  <= it.pix.src_alpha;
    in_if.dst_red    <= it.pix.dst_red;
    in_if.dst_green  <= it.pix.dst_green;
    in_if.dst_blue   <= it.pix.dst_blue;
    in_if.last_pixel <= it.last;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    pending_writes.push_back(predict_write(it));
    burst_left--;
  endtask

  // Send a w x h source image of random pixels, last_pixel on the final one
  task automatic send_image(int w, int h);
    for (int i = 0; i < w * h; i++)
      send_pixel(random_pixel(i == w * h - 1));
  endtask

  // Drop valid and wait until every predicted write has come out
  task automatic wait_idle();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    burst_left = 0;
  endtask

  task automatic write_reg(cab_cfg_idx_t idx, int value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= CAB_CFG_DATA_W'(value);
    apply_reg(idx, CAB_CFG_DATA_W'(value));
  endtask

  // Write all seven registers while the block is idle
  task automatic configure(int dx, int dy, int sw, int cl, int ct, int spx, int spy);
    wait_idle();
    write_reg(CFG_DEST_X, dx);
    write_reg(CFG_DEST_Y, dy);
    write_reg(CFG_SOURCE_WIDTH, sw);
    write_reg(CFG_CLIP_LEFT, cl);
    write_reg(CFG_CLIP_TOP, ct);
    write_reg(CFG_CLIP_SPAN_X, spx);
    write_reg(CFG_CLIP_SPAN_Y, spy);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Reset registers put every pixel on its own row at column 0; walk the
  // alpha and channel extremes: copy, drop on zero alpha, blends near both ends.
  task automatic test_reset_blend();
    send_pixel(make_pixel(255, 0, 128, 255, 7, 8, 9, 1'b0));
    send_pixel(make_pixel(200, 100, 50, 0, 1, 2, 3, 1'b0));
    send_pixel(make_pixel(255, 255, 255, 1, 0, 0, 0, 1'b0));
    send_pixel(make_pixel(0, 0, 0, 254, 255, 255, 255, 1'b0));
    send_pixel(make_pixel(255, 0, 255, 128, 0, 255, 0, 1'b0));
    send_pixel(make_pixel(170, 85, 1, 127, 85, 170, 254, 1'b1));
  endtask

  // Image straddles the top and right canvas edges
  task automatic test_canvas_edges();
    configure(CANVAS_W - 3, -1, 5, COORD_MIN, COORD_MIN, SPAN_FULL, SPAN_FULL);
    send_image(5, 2);
  endtask

  // Clip rectangle cuts the image; then zero spans clip everything
  task automatic test_clip_edges();
    configure(0, CANVAS_H - 2, 4, 1, CANVAS_H - 1, 2, 1);
    send_image(4, 2);
    configure(0, 0, 4, 0, 0, 0, SPAN_FULL);
    send_image(2, 1);
    configure(0, 0, 2, 0, 0, SPAN_FULL, 0);
    send_image(2, 1);
  endtask

  // Zero source width: every pixel ends its row
  task automatic test_width_zero();
    configure(0, 0, 0, 0, 0, SPAN_FULL, SPAN_FULL);
    send_image(3, 1);
  endtask

  // Stall the receiver for a long stretch while the sender keeps offering
  task automatic test_backpressure();
    configure(3, 5, 16, 0, 0, SPAN_FULL, SPAN_FULL);
    steady_send = 1'b1;
    @(posedge clk);
    hold_off_cycles = HOLD_CYCLES;
    send_image(16, 3);
    steady_send = 1'b0;
  endtask

  // Random placements near the canvas and clip edges, mostly whole images,
  // with stray last_pixel marks and missing ones mixed in.
  task automatic test_random();
    int sent;
    int phase;
    int dx, dy, sw, cl, ct, spx, spy, w, h;
    bit last;
    sent  = 0;
    phase = 0;
    while (sent < RANDOM_ITEMS) begin
      if (phase == 0) begin
        configure(COORD_MIN, COORD_MAX, WIDTH_MAX, COORD_MIN, COORD_MAX, 0, SPAN_MAX);
        w = 4;
      end else if (phase == 1) begin
        configure(COORD_MAX, COORD_MIN, COL_LIMIT, COORD_MAX, COORD_MIN, SPAN_MAX, 0);
        w = 4;
      end else begin
        case ($urandom_range(0, 9))
          0:       sw = 0;
          1:       sw = COL_LIMIT;
          2:       sw = $urandom_range(COL_LIMIT + 1, WIDTH_MAX);
          default: sw = $urandom_range(1, 20);
        endcase
        w = (sw >= 1 && sw <= 20) ? sw : $urandom_range(1, 8);
        case ($urandom_range(0, 5))
          0:       dx = COORD_MIN;
          1:       dx = COORD_MAX;
          2:       dx = int'($urandom_range(0, 8)) - w;
          3:       dx = CANVAS_W - int'($urandom_range(1, 8));
          default: dx = $urandom_range(0, CANVAS_W - 1);
        endcase
        case ($urandom_range(0, 5))
          0:       dy = COORD_MIN;
          1:       dy = COORD_MAX;
          2:       dy = int'($urandom_range(0, 5)) - 3;
          3:       dy = CANVAS_H - int'($urandom_range(1, 5));
          default: dy = $urandom_range(0, CANVAS_H - 1);
        endcase
        case ($urandom_range(0, 5))
          0:       cl = COORD_MIN;
          1:       cl = COORD_MAX;
          default: cl = dx - 3 + int'($urandom_range(0, 6));
        endcase
        case ($urandom_range(0, 5))
          0:       ct = COORD_MIN;
          1:       ct = COORD_MAX;
          default: ct = dy - 2 + int'($urandom_range(0, 4));
        endcase
        case ($urandom_range(0, 5))
          0:       spx = 0;
          1:       spx = SPAN_FULL;
          2:       spx = SPAN_MAX;
          default: spx = $urandom_range(1, 10);
        endcase
        case ($urandom_range(0, 5))
          0:       spy = 0;
          1:       spy = SPAN_FULL;
          2:       spy = SPAN_MAX;
          default: spy = $urandom_range(1, 6);
        endcase
        configure(dx, dy, sw, cl, ct, spx, spy);
      end
      phase++;
      repeat ($urandom_range(2, 4)) begin
        h = $urandom_range(1, 5);
        for (int i = 0; i < w * h && sent < RANDOM_ITEMS; i++) begin
          // Mostly close the image cleanly; sometimes end early or run on
          if (i == w * h - 1)
            last = ($urandom_range(0, 7) != 0);
          else
            last = ($urandom_range(0, 49) == 0);
          send_pixel(random_pixel(last));
          sent++;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_wdata        = '0;
    in_if.valid      = 1'b0;
    in_if.src_red    = '0;
    in_if.src_green  = '0;
    in_if.src_blue   = '0;
    in_if.src_alpha  = '0;
    in_if.dst_red    = '0;
    in_if.dst_green  = '0;
    in_if.dst_blue   = '0;
    in_if.last_pixel = 1'b0;
    mismatch_count   = 0;
    burst_left       = 0;
    steady_send      = 1'b0;
    hold_off_cycles  = 0;
    // Register and counter values after reset
    reg_dest_x    = 0;
    reg_dest_y    = 0;
    reg_src_width = 1;
    reg_clip_left = 0;
    reg_clip_top  = 0;
    reg_span_x    = SPAN_FULL;
    reg_span_y    = SPAN_FULL;
    col_count     = 0;
    row_count     = 0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_blend();
    test_canvas_edges();
    test_clip_edges();
    test_width_zero();
    test_backpressure();
    test_random();

    // Drain everything in flight, then let the pipeline settle
    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_writes.size() == 0)
      $display("clipped_alpha_blit_unit_tb OK");
    else
      $display("clipped_alpha_blit_unit_tb NOT OK");
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/cab_pkg.sv
hdl/cab_in_if.sv
hdl/cab_out_if.sv
hdl/cab_blend.sv
hdl/clipped_alpha_blit_unit.sv
test/clipped_alpha_blit_unit_tb.sv
